>>> sv/deq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deq_pkg: shared definitions of the double-ended queue
// Operation codes, status codes and default sizing used by the queue modules.
// ----------------------------------------------------------------------------
package deq_pkg;

   // Default number of ring buffer entries.
   localparam int unsigned DEPTH_DEFAULT = 64;

   // Width of one stored value.
   localparam int unsigned VALUE_W = 32;

   // Operation carried in the request sideband.
   typedef enum logic [2:0] {
      FUNC_PUSH_FRONT = 3'd0,
      FUNC_PUSH_BACK  = 3'd1,
      FUNC_POP_FRONT  = 3'd2,
      FUNC_POP_BACK   = 3'd3,
      FUNC_DUMP       = 3'd4
   } func_type;

   // Status carried in the response sideband.
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

endpackage
`default_nettype wire

>>> sv/deq_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deq_mem: entry storage of the double-ended queue
// Simple dual-port memory, one write and one read per cycle, registered read.
// ----------------------------------------------------------------------------
module deq_mem #(
   parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]             wr_addr,
   input  wire logic signed [deq_pkg::VALUE_W-1:0]   wr_data,
   input  wire logic                                 rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]             rd_addr,
   output logic signed [deq_pkg::VALUE_W-1:0]        rd_data
);

   logic signed [deq_pkg::VALUE_W-1:0] mem_ff [DEPTH];
   logic signed [deq_pkg::VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // The read register holds its value until the next read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> sv/deq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deq_ctrl: pointer logic, sequencer and response register of the queue
// Tracks front and occupancy, drives the memory and holds one response.
// ----------------------------------------------------------------------------
module deq_ctrl #(
   parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // Request channel
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic signed [deq_pkg::VALUE_W-1:0]   req_tdata,
   input  wire logic [2:0]                           req_tuser,
   // Response channel
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic signed [deq_pkg::VALUE_W-1:0]        rsp_tdata,
   output logic [1:0]                                rsp_tuser,
   output logic                                      rsp_tlast,
   // Memory port
   output logic                                      mem_wr_en,
   output logic [$clog2(DEPTH)-1:0]                  mem_wr_addr,
   output logic signed [deq_pkg::VALUE_W-1:0]        mem_wr_data,
   output logic                                      mem_rd_en,
   output logic [$clog2(DEPTH)-1:0]                  mem_rd_addr,
   input  wire logic signed [deq_pkg::VALUE_W-1:0]   mem_rd_data
);

   localparam int unsigned IDX_W = $clog2(DEPTH);
   localparam int unsigned OCC_W = $clog2(DEPTH + 1);
   localparam int unsigned SUM_W = OCC_W + 1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_POP  = 3'b010,
      ST_DUMP = 3'b100
   } state_type;

   state_type                          state_ff, state_in;
   logic [IDX_W-1:0]                   front_ff, front_in;
   logic [OCC_W-1:0]                   occ_ff, occ_in;
   logic [OCC_W-1:0]                   cnt_ff, cnt_in;
   logic [IDX_W-1:0]                   slot_ff, slot_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [deq_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   deq_pkg::status_type                rsp_status_ff, rsp_status_in;
   logic                               rsp_last_ff, rsp_last_in;

   logic                               out_free;
   logic                               req_fire;
   logic                               full;
   logic                               empty;
   deq_pkg::func_type                  func;
   logic [IDX_W-1:0]                   front_dec;
   logic [IDX_W-1:0]                   front_inc;
   logic [SUM_W-1:0]                   back_sum;
   logic [SUM_W-1:0]                   tail_sum;
   logic [IDX_W-1:0]                   back_slot;
   logic [IDX_W-1:0]                   tail_slot;

   // Step an index forward by one, wrapping at the ring size.
   function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] res;
      if (idx == IDX_W'(DEPTH - 1)) begin
         res = '0;
      end else begin
         res = idx + 1'b1;
      end
      return res;
   endfunction

   // Bring a sum below twice the ring size back into range.
   function automatic logic [IDX_W-1:0] idx_wrap(input logic [SUM_W-1:0] sum);
      logic [SUM_W-1:0] res;
      if (sum >= SUM_W'(DEPTH)) begin
         res = sum - SUM_W'(DEPTH);
      end else begin
         res = sum;
      end
      return res[IDX_W-1:0];
   endfunction

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign req_fire   = req_tvalid && req_tready;
   assign func       = deq_pkg::func_type'(req_tuser);
   assign full       = (occ_ff == OCC_W'(DEPTH));
   assign empty      = (occ_ff == '0);

   assign front_dec = (front_ff == '0) ? IDX_W'(DEPTH - 1) : front_ff - 1'b1;
   assign front_inc = idx_inc(front_ff);
   // Slot just past the back, and the back slot itself.
   assign back_sum  = SUM_W'(front_ff) + SUM_W'(occ_ff);
   assign tail_sum  = back_sum - 1'b1;
   assign back_slot = idx_wrap(back_sum);
   assign tail_slot = idx_wrap(tail_sum);

   always_comb begin
      state_in      = state_ff;
      front_in      = front_ff;
      occ_in        = occ_ff;
      cnt_in        = cnt_ff;
      slot_in       = slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = back_slot;
      mem_wr_data   = req_tdata;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = front_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (func)
                  deq_pkg::FUNC_PUSH_FRONT, deq_pkg::FUNC_PUSH_BACK: begin
                     rsp_valid_in = 1'b1;
                     rsp_value_in = '0;
                     rsp_last_in  = 1'b1;
                     if (full) begin
                        rsp_status_in = deq_pkg::STATUS_FULL;
                     end else begin
                        rsp_status_in = deq_pkg::STATUS_OK;
                        mem_wr_en     = 1'b1;
                        occ_in        = occ_ff + 1'b1;
                        if (func == deq_pkg::FUNC_PUSH_FRONT) begin
                           mem_wr_addr = front_dec;
                           front_in    = front_dec;
                        end
                     end
                  end
                  deq_pkg::FUNC_POP_FRONT, deq_pkg::FUNC_POP_BACK: begin
                     if (empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_value_in  = '0;
                        rsp_status_in = deq_pkg::STATUS_EMPTY;
                        rsp_last_in   = 1'b1;
                     end else begin
                        mem_rd_en = 1'b1;
                        occ_in    = occ_ff - 1'b1;
                        state_in  = ST_POP;
                        if (func == deq_pkg::FUNC_POP_FRONT) begin
                           front_in = front_inc;
                        end else begin
                           mem_rd_addr = tail_slot;
                        end
                     end
                  end
                  deq_pkg::FUNC_DUMP: begin
                     if (empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_value_in  = '0;
                        rsp_status_in = deq_pkg::STATUS_EMPTY;
                        rsp_last_in   = 1'b1;
                     end else begin
                        mem_rd_en = 1'b1;
                        slot_in   = front_inc;
                        cnt_in    = '0;
                        state_in  = ST_DUMP;
                     end
                  end
                  default: begin
                     // Unused operation codes are taken and dropped.
                  end
               endcase
            end
         end
         ST_POP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = mem_rd_data;
               rsp_status_in = deq_pkg::STATUS_OK;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_DUMP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = mem_rd_data;
               rsp_status_in = deq_pkg::STATUS_OK;
               rsp_last_in   = (OCC_W'(cnt_ff + 1'b1) == occ_ff);
               if (rsp_last_in) begin
                  state_in = ST_IDLE;
               end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = slot_ff;
                  slot_in     = idx_inc(slot_ff);
                  cnt_in      = cnt_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      slot_ff       <= slot_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(DEPTH))
      else $error("occupancy beyond ring size");

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == ST_IDLE)
      else $error("request taken while busy");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !full && (func == deq_pkg::FUNC_PUSH_FRONT ||
         func == deq_pkg::FUNC_PUSH_BACK)) |=> occ_ff == $past(occ_ff) + 1'b1)
      else $error("push did not grow the queue");

   a_dump_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DUMP |-> !mem_wr_en && cnt_ff < occ_ff)
      else $error("dump out of range or overlapping a write");

   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_fire)
      else $error("request accepted during a read");
`endif

endmodule
`default_nettype wire

>>> sv/double_ended_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue: bounded double-ended queue of signed 32-bit values
// Ring buffer in a registered-read memory with front and occupancy pointers.
// ----------------------------------------------------------------------------
// Timing: a push or any empty or full answer appears in the cycle after its
//   request; a pop or dump value passes the memory read register and then the
//   response register. Pushes go one per cycle while replies are taken; a pop
//   or a dump holds the request channel until its last value is registered,
//   and a dump streams one stored value per cycle while replies are taken.
// Reset: synchronous, active high; the queue comes up empty at once. The
//   entry memory is not cleared, since only entries written by a push are read.
// ----------------------------------------------------------------------------
module double_ended_queue #(
   parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // Request channel
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic signed [deq_pkg::VALUE_W-1:0]   req_tdata,  // [31:0] push_value
   input  wire logic [2:0]                           req_tuser,  // [2:0] func
   // Response channel
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic signed [deq_pkg::VALUE_W-1:0]        rsp_tdata,  // [31:0] out_value
   output logic [1:0]                                rsp_tuser,  // [1:0] status
   output logic                                      rsp_tlast
);

   localparam int unsigned IDX_W = $clog2(DEPTH);

   // Memory port between the sequencer and the entry store.
   logic                               mem_wr_en;
   logic [IDX_W-1:0]                   mem_wr_addr;
   logic signed [deq_pkg::VALUE_W-1:0] mem_wr_data;
   logic                               mem_rd_en;
   logic [IDX_W-1:0]                   mem_rd_addr;
   logic signed [deq_pkg::VALUE_W-1:0] mem_rd_data;

   // The sequencer owns the pointers and the response register. Writes only
   // happen for pushes and reads only for pops and dumps, and a read never
   // shares a cycle with a write, so no forwarding is needed.
   deq_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   // Entry store: one write and one registered read per cycle.
   deq_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule
`default_nettype wire

>>> tb/deq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_checker: reply predictor and scoreboard for the double-ended queue
// Follows every accepted request with its own copy of the ring buffer, queues
// the replies it should cause, and compares each accepted reply with them.
// ----------------------------------------------------------------------------
module deq_checker #(
   parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic signed [deq_pkg::VALUE_W-1:0]  req_tdata,
   input  logic [2:0]                          req_tuser,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic signed [deq_pkg::VALUE_W-1:0]  rsp_tdata,
   input  logic [1:0]                          rsp_tuser,
   input  logic                                rsp_tlast,
   output int unsigned                         failures,
   output int unsigned                         pending,
   output int unsigned                         replies_checked,
   output int unsigned                         full_hits,
   output int unsigned                         empty_hits
);

   localparam int unsigned IDX_W = $clog2(DEPTH);

   typedef struct packed {
      logic signed [deq_pkg::VALUE_W-1:0] value;
      deq_pkg::status_type                status;
      logic                               last;
   } reply_type;

   logic signed [deq_pkg::VALUE_W-1:0] shadow_store [DEPTH];
   logic [IDX_W-1:0]                   front_slot;
   logic [IDX_W:0]                     fill_level;
   reply_type                          awaited_replies [$];

   initial begin
      failures        = 0;
      pending         = 0;
      replies_checked = 0;
      full_hits       = 0;
      empty_hits      = 0;
      front_slot      = '0;
      fill_level      = '0;
   end

   function automatic logic [IDX_W-1:0] ring_slot(input int unsigned offset);
      return IDX_W'((int'(front_slot) + offset) % DEPTH);
   endfunction

   function automatic void await_reply(input logic signed [deq_pkg::VALUE_W-1:0] value,
                                       input deq_pkg::status_type status,
                                       input logic last);
      reply_type r;
      r.value  = value;
      r.status = status;
      r.last   = last;
      awaited_replies.push_back(r);
   endfunction

   // Applies one request to the shadow queue and lines up what it answers.
   task automatic model_request(input logic [2:0] code,
                                input logic signed [deq_pkg::VALUE_W-1:0] value);
      logic [IDX_W-1:0] slot;
      case (code)
         deq_pkg::FUNC_PUSH_FRONT, deq_pkg::FUNC_PUSH_BACK: begin
            if (fill_level >= DEPTH) begin
               await_reply('0, deq_pkg::STATUS_FULL, 1'b1);
            end else begin
               if (code == deq_pkg::FUNC_PUSH_FRONT) begin
                  front_slot = ring_slot(DEPTH - 1);
                  slot       = front_slot;
               end else begin
                  slot = ring_slot(32'(fill_level));
               end
               shadow_store[slot] = value;
               fill_level++;
               await_reply('0, deq_pkg::STATUS_OK, 1'b1);
            end
         end
         deq_pkg::FUNC_POP_FRONT, deq_pkg::FUNC_POP_BACK: begin
            if (fill_level == 0) begin
               await_reply('0, deq_pkg::STATUS_EMPTY, 1'b1);
            end else begin
               if (code == deq_pkg::FUNC_POP_FRONT) begin
                  slot       = front_slot;
                  front_slot = ring_slot(1);
               end else begin
                  slot = ring_slot(32'(fill_level) - 1);
               end
               fill_level--;
               await_reply(shadow_store[slot], deq_pkg::STATUS_OK, 1'b1);
            end
         end
         deq_pkg::FUNC_DUMP: begin
            if (fill_level == 0) begin
               await_reply('0, deq_pkg::STATUS_EMPTY, 1'b1);
            end else begin
               for (int unsigned i = 0; i < fill_level; i++)
                  await_reply(shadow_store[ring_slot(i)], deq_pkg::STATUS_OK,
                              (i + 1) == fill_level);
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_reply();
      reply_type want;
      if (awaited_replies.size() == 0) begin
         $error("reply transaction with none outstanding: out_value %h status %0d last %0b",
                rsp_tdata, rsp_tuser, rsp_tlast);
         failures++;
      end else begin
         want = awaited_replies.pop_front();
         replies_checked++;
         if (want.status == deq_pkg::STATUS_FULL)
            full_hits++;
         if (want.status == deq_pkg::STATUS_EMPTY)
            empty_hits++;
         if (rsp_tdata !== want.value) begin
            $error("field out_value: expected %h, actual %h", want.value, rsp_tdata);
            failures++;
         end
         if (rsp_tuser !== want.status) begin
            $error("field status: expected %0d, actual %0d", want.status, rsp_tuser);
            failures++;
         end
         if (rsp_tlast !== want.last) begin
            $error("field last: expected %0b, actual %0b", want.last, rsp_tlast);
            failures++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         front_slot = '0;
         fill_level = '0;
         awaited_replies.delete();
      end else begin
         if (req_tvalid && req_tready)
            model_request(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready)
            check_reply();
      end
      pending = awaited_replies.size();
   end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top of the double-ended queue
// Drives directed and then biased random request traffic in bursts, holds the
// reply channel back on a shifting pattern, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;

   // Function codes that the queue must ignore without answering.
   localparam logic [2:0] FUNC_UNUSED_LO = 3'd5;
   localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;

   // Requests with a real operation sent by the random part.
   localparam int unsigned RANDOM_ITEMS = 440;
   // Cycles without any transaction before the run is declared hung. The
   // longest honest pause is a sender gap plus a receiver stall, so this leaves
   // a wide margin.
   localparam int unsigned IDLE_LIMIT = 2000;
   // Quiet cycles after the last reply, well beyond the pop latency, so that any
   // stray reply still gets caught.
   localparam int unsigned DRAIN_CYCLES = 8;

   // The random part cycles through these to reach both a full and an empty
   // queue rather than hovering around half full.
   typedef enum logic [1:0] {
      FILLING,
      MIXING,
      DRAINING
   } traffic_mode_type;

   // How the receiver treats the reply channel over a stretch of cycles.
   typedef enum logic [1:0] {
      SINK_OPEN,
      SINK_COIN,
      SINK_SPARSE,
      SINK_BLOCKED
   } sink_style_type;

   logic                                clock      = 1'b0;
   logic                                reset      = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic signed [deq_pkg::VALUE_W-1:0]  req_tdata  = '0;
   logic [2:0]                          req_tuser  = deq_pkg::FUNC_PUSH_FRONT;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic signed [deq_pkg::VALUE_W-1:0]  rsp_tdata;
   logic [1:0]                          rsp_tuser;
   logic                                rsp_tlast;

   int unsigned failures;
   int unsigned pending;
   int unsigned replies_checked;
   int unsigned full_hits;
   int unsigned empty_hits;

   int unsigned burst_left = 0;
   int unsigned sent_per_code [8];

   double_ended_queue #(
      .DEPTH (deq_pkg::DEPTH_DEFAULT)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   deq_checker #(
      .DEPTH (deq_pkg::DEPTH_DEFAULT)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .failures        (failures),
      .pending         (pending),
      .replies_checked (replies_checked),
      .full_hits       (full_hits),
      .empty_hits      (empty_hits)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Push values: mostly random words, with the corner values mixed in now and
   // then so that sign and carry boundaries pass through the store often.
   function automatic logic signed [deq_pkg::VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 15))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return 32'sh0000_0000;
         3:       return 32'shFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   // Sends one request transaction. The sender works in bursts: when a burst is
   // used up it drops tvalid for a random gap, sometimes none at all, and then
   // picks the length of the next burst. Within a burst tvalid stays high from
   // one transaction to the next. Everything changes at the falling edge and
   // the handshake is judged at the rising edge.
   task automatic send_request(input logic [2:0] code,
                               input logic signed [deq_pkg::VALUE_W-1:0] value);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         repeat (gap) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
         burst_left = $urandom_range(1, 24);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= code;
      req_tdata  <= value;
      do
         @(posedge clock);
      while (!req_tready);
      burst_left--;
      sent_per_code[code]++;
   endtask

   // Receiver back-pressure. Every stretch picks a style: always ready, a coin
   // toss per cycle, ready one cycle in four, or a short hard stall. This puts
   // stalls in the middle of dumps as well as on single replies.
   initial begin : reply_sink
      sink_style_type style;
      int unsigned    style_left;
      int unsigned    tick;
      style      = SINK_OPEN;
      style_left = 0;
      tick       = 0;
      forever begin
         @(negedge clock);
         if (style_left == 0) begin
            style      = sink_style_type'($urandom_range(0, 3));
            style_left = (style == SINK_BLOCKED) ? $urandom_range(2, 12)
                                                 : $urandom_range(20, 80);
         end
         style_left--;
         tick++;
         case (style)
            SINK_OPEN:    rsp_tready <= 1'b1;
            SINK_COIN:    rsp_tready <= 1'($urandom_range(0, 1));
            SINK_SPARSE:  rsp_tready <= (tick % 4) == 0;
            default:      rsp_tready <= 1'b0;
         endcase
      end
   end

   // Gives up when neither channel has moved a transaction for too long.
   initial begin : watchdog
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Timed out: no transaction for %0d cycles, %0d replies outstanding.",
               IDLE_LIMIT, pending);
      $display("double_ended_queue: mismatch");
      $finish;
   end

   initial begin : stimulus
      traffic_mode_type mode;
      int unsigned      mode_left;
      int unsigned      valid_items;
      int unsigned      roll;
      int unsigned      push_share;
      int unsigned      unused_sent;
      logic [2:0]       code;

      // Reset is held at the start and released at a falling edge.
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Directed part. First the empty queue: both pops and a dump must answer
      // empty, and the unused codes must pass without any reply.
      send_request(deq_pkg::FUNC_POP_FRONT, pick_value());
      send_request(deq_pkg::FUNC_POP_BACK, pick_value());
      send_request(deq_pkg::FUNC_DUMP, pick_value());
      for (int c = FUNC_UNUSED_LO; c <= FUNC_UNUSED_HI; c++)
         send_request(3'(c), pick_value());

      // Extreme values at both ends. The first push to the front wraps the
      // front pointer from slot zero round to the top of the ring.
      send_request(deq_pkg::FUNC_PUSH_BACK, 32'sh7FFF_FFFF);
      send_request(deq_pkg::FUNC_PUSH_FRONT, 32'sh8000_0000);
      send_request(deq_pkg::FUNC_PUSH_BACK, 32'sh0000_0000);
      send_request(deq_pkg::FUNC_PUSH_FRONT, 32'shFFFF_FFFF);
      send_request(deq_pkg::FUNC_PUSH_BACK, 32'sh5555_5555);
      send_request(deq_pkg::FUNC_PUSH_FRONT, 32'shAAAA_AAAA);
      send_request(deq_pkg::FUNC_DUMP, pick_value());

      // Take the queue apart from both ends, dump it half way, and pop once
      // more when it is empty again.
      send_request(deq_pkg::FUNC_POP_FRONT, pick_value());
      send_request(deq_pkg::FUNC_POP_BACK, pick_value());
      send_request(deq_pkg::FUNC_POP_FRONT, pick_value());
      send_request(deq_pkg::FUNC_DUMP, pick_value());
      send_request(deq_pkg::FUNC_POP_BACK, pick_value());
      send_request(deq_pkg::FUNC_POP_FRONT, pick_value());
      send_request(deq_pkg::FUNC_POP_BACK, pick_value());
      send_request(deq_pkg::FUNC_POP_FRONT, pick_value());

      // Random part. Long filling stretches drive the queue into full, where
      // pushes must be refused, and draining stretches empty it again; the
      // mixed stretches in between keep both pointers wandering round the
      // ring. Dumps come in every mode, so some stream the whole queue. A few
      // unused codes are scattered in as noise and are not counted.
      mode        = DRAINING;
      mode_left   = 0;
      valid_items = 0;
      while (valid_items < RANDOM_ITEMS) begin
         if (mode_left == 0) begin
            case (mode)
               FILLING: mode = MIXING;
               MIXING:  mode = DRAINING;
               default: mode = FILLING;
            endcase
            mode_left = (mode == MIXING) ? $urandom_range(30, 80) : $urandom_range(100, 140);
         end
         mode_left--;
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            code = 3'($urandom_range(FUNC_UNUSED_HI, FUNC_UNUSED_LO));
         end else if (roll < 8) begin
            code = deq_pkg::FUNC_DUMP;
         end else begin
            push_share = (mode == FILLING) ? 80 : (mode == DRAINING) ? 20 : 50;
            if ($urandom_range(0, 99) < push_share)
               code = $urandom_range(0, 1) ? deq_pkg::FUNC_PUSH_BACK
                                           : deq_pkg::FUNC_PUSH_FRONT;
            else
               code = $urandom_range(0, 1) ? deq_pkg::FUNC_POP_BACK
                                           : deq_pkg::FUNC_POP_FRONT;
         end
         send_request(code, pick_value());
         if (code <= deq_pkg::FUNC_DUMP)
            valid_items++;
      end

      // The last transaction went at the rising edge just passed; idle the
      // request channel, let every outstanding reply arrive, then keep
      // watching a little longer for anything unexpected.
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      unused_sent = 0;
      for (int c = FUNC_UNUSED_LO; c <= FUNC_UNUSED_HI; c++)
         unused_sent += sent_per_code[c];

      $display("Covered %0d push front, %0d push back, %0d pop front, %0d pop back, %0d dump,",
               sent_per_code[deq_pkg::FUNC_PUSH_FRONT], sent_per_code[deq_pkg::FUNC_PUSH_BACK],
               sent_per_code[deq_pkg::FUNC_POP_FRONT], sent_per_code[deq_pkg::FUNC_POP_BACK],
               sent_per_code[deq_pkg::FUNC_DUMP]);
      $display("%0d ignored codes; %0d replies checked, %0d refused pushes, %0d empty answers.",
               unused_sent, replies_checked, full_hits, empty_hits);
      if (failures == 0)
         $display("double_ended_queue: match");
      else
         $display("double_ended_queue: mismatch");
      $finish;
   end

endmodule
